>>> rtl/pts_pkg.sv
`timescale 1ns / 1ps

package pts_pkg;

	localparam int LEVELS    = 3;
	localparam int QDEPTH    = 16;
	localparam int PTR_W     = 4;
	localparam int CNT_W     = 5;
	localparam int ID_W      = 5;
	localparam int TAG_W     = 16;
	localparam int QUANTUM_W = 16;
	localparam int LEVEL_W   = 2;
	localparam int MAX_TASKS = 16;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_REGISTER = 2'd1,
		OP_EXIT     = 2'd2
	} opcode_t;

	localparam logic [LEVEL_W-1:0] LVL_HIGH   = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_MEDIUM = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_LOW    = 2'd2;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [1:0]       priority_req;
		logic [TAG_W-1:0] task_tag;
	} item_t;

	typedef struct packed {
		logic             running_valid;
		logic [ID_W-1:0]  running_id;
		logic [TAG_W-1:0] running_tag;
		logic             switched;
		logic             register_ok;
		logic [ID_W-1:0]  assigned_id;
	} result_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [TAG_W-1:0] tag;
	} entry_t;

endpackage

>>> rtl/pts_queue.sv
`timescale 1ns / 1ps

module pts_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pts_pkg::entry_t       push_entry,
	input  logic                  pop,
	output logic [pts_pkg::CNT_W-1:0] count,
	output pts_pkg::entry_t       head_entry
);
	import pts_pkg::*;

	entry_t             mem_q [QDEPTH];
	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [CNT_W-1:0]   count_q;

	// Entry storage needs no reset; only counted entries are ever used.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_q + PTR_W'(1);
			end
			if (pop) begin
				head_q <= head_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign count      = count_q;
	assign head_entry = mem_q[head_q];

endmodule

>>> rtl/three_level_priority_task_scheduler_unit.sv
`timescale 1ns / 1ps
// A word taken into the input register is decoded there, and its result word is captured
// in the result register and offered from it; a refused result holds the next word back.
// Throughput: one word per cycle while results drain, as each word takes one registered pass.
// Reset (arst_n low, asynchronous): all queues empty, no task running, next id 1,
// task count 0, default quantum 1. Queue entry storage is not reset.
module three_level_priority_task_scheduler_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  pts_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output pts_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [pts_pkg::QUANTUM_W-1:0] cfg_data
);
	import pts_pkg::*;

	// Input register stage.
	item_t item_s1;
	logic  valid_s1;

	// Result register stage.
	result_t result_s2;
	logic    valid_s2;

	// Configuration and scheduler state.
	logic [QUANTUM_W-1:0] default_quantum_q;
	logic [ID_W-1:0]      cur_id_q;
	logic [TAG_W-1:0]     cur_tag_q;
	logic [LEVEL_W-1:0]   cur_level_q;
	logic [QUANTUM_W-1:0] cur_quantum_q;
	logic                 cur_done_q;
	logic [ID_W-1:0]      next_id_q;
	logic [CNT_W-1:0]     task_count_q;

	// Queue interface.
	logic [CNT_W-1:0] q_count [LEVELS];
	entry_t           q_head  [LEVELS];
	logic [LEVELS-1:0] q_full;
	logic [LEVELS-1:0] q_push;
	logic [LEVELS-1:0] q_pop;

	// Decode of the word in the input register.
	logic                 advance;
	logic                 push_valid;
	logic [LEVEL_W-1:0]   push_level;
	entry_t               push_entry;
	logic                 do_pick;
	logic                 reg_ok;
	logic [LEVEL_W-1:0]   req_level;
	logic                 cur_full;
	logic [QUANTUM_W-1:0] quantum_nxt;
	logic                 done_nxt;

	// Pick of the next running task.
	logic [LEVELS-1:0]  eff_nonempty;
	entry_t             eff_head [LEVELS];
	logic               pick_found;
	logic [LEVEL_W-1:0] pick_level;
	entry_t             pick_entry;

	logic [ID_W-1:0]      id_new;
	logic [TAG_W-1:0]     tag_new;
	logic [LEVEL_W-1:0]   level_new;
	logic [QUANTUM_W-1:0] quantum_new;
	logic                 done_new;

	// The input register moves forward whenever the result register is empty or is being
	// drained in the same cycle, so a finished result holds back the next word only while
	// the receiver refuses it.
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_quantum_q <= QUANTUM_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			default_quantum_q <= cfg_data;
		end
	end

	// Three ready queues, one per priority level.
	for (genvar l = 0; l < LEVELS; l++) begin : g_queue
		pts_queue u_queue (
			.clk        (clk),
			.arst_n     (arst_n),
			.push       (q_push[l]),
			.push_entry (push_entry),
			.pop        (q_pop[l]),
			.count      (q_count[l]),
			.head_entry (q_head[l])
		);
		assign q_full[l] = (q_count[l] == CNT_W'(QDEPTH));
		assign q_push[l] = advance && push_valid && (push_level == LEVEL_W'(l));
		assign q_pop[l]  = advance && do_pick && pick_found && (pick_level == LEVEL_W'(l));
		// A requeue into an empty queue is visible to the pick in the same pass.
		assign eff_nonempty[l] = (q_count[l] != '0) || q_push[l];
		assign eff_head[l]     = (q_count[l] == '0) ? push_entry : q_head[l];
	end

	// Priority code 3 folds into the low level.
	assign req_level = (item_s1.priority_req >= LVL_LOW) ? LVL_LOW : item_s1.priority_req;

	always_comb begin
		unique case (cur_level_q)
			LVL_HIGH:   cur_full = q_full[0];
			LVL_MEDIUM: cur_full = q_full[1];
			default:    cur_full = q_full[2];
		endcase
	end

	// Decide what the word does: which entry goes into which queue, whether a pick runs,
	// and how the running task's quantum and done flag move.
	always_comb begin
		push_valid       = 1'b0;
		push_level       = cur_level_q;
		push_entry.id    = cur_id_q;
		push_entry.tag   = cur_tag_q;
		do_pick          = 1'b0;
		reg_ok           = 1'b0;
		quantum_nxt      = cur_quantum_q;
		done_nxt         = cur_done_q;
		case (item_s1.opcode)
			OP_TICK: begin
				priority if (cur_id_q == '0) begin
					do_pick = 1'b1;
				end else if (cur_quantum_q != '0) begin
					quantum_nxt = cur_quantum_q - QUANTUM_W'(1);
				end else if (cur_done_q) begin
					do_pick = 1'b1;
				end else if (!cur_full) begin
					push_valid = 1'b1;
					do_pick    = 1'b1;
				end else begin
					// Its own queue is full: the task keeps running with a fresh quantum.
					quantum_nxt = default_quantum_q;
				end
			end
			OP_REGISTER: begin
				if ((task_count_q < CNT_W'(MAX_TASKS)) && !q_full[req_level]) begin
					push_valid     = 1'b1;
					push_level     = req_level;
					push_entry.id  = next_id_q;
					push_entry.tag = item_s1.task_tag;
					reg_ok         = 1'b1;
				end
			end
			OP_EXIT: begin
				if (cur_id_q != '0) begin
					done_nxt = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Highest nonempty queue wins.
	always_comb begin
		priority if (eff_nonempty[0]) begin
			pick_found = 1'b1;
			pick_level = LVL_HIGH;
			pick_entry = eff_head[0];
		end else if (eff_nonempty[1]) begin
			pick_found = 1'b1;
			pick_level = LVL_MEDIUM;
			pick_entry = eff_head[1];
		end else if (eff_nonempty[2]) begin
			pick_found = 1'b1;
			pick_level = LVL_LOW;
			pick_entry = eff_head[2];
		end else begin
			pick_found = 1'b0;
			pick_level = LVL_HIGH;
			pick_entry = '0;
		end
	end

	always_comb begin
		id_new      = cur_id_q;
		tag_new     = cur_tag_q;
		level_new   = cur_level_q;
		quantum_new = quantum_nxt;
		done_new    = done_nxt;
		if (do_pick) begin
			if (pick_found) begin
				id_new      = pick_entry.id;
				tag_new     = pick_entry.tag;
				level_new   = pick_level;
				quantum_new = default_quantum_q;
			end else begin
				// Nothing ready: the scheduler goes idle with all fields cleared.
				id_new      = '0;
				tag_new     = '0;
				level_new   = '0;
				quantum_new = '0;
			end
			done_new = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_id_q      <= '0;
			cur_tag_q     <= '0;
			cur_level_q   <= '0;
			cur_quantum_q <= '0;
			cur_done_q    <= 1'b0;
			next_id_q     <= ID_W'(1);
			task_count_q  <= '0;
		end else if (advance) begin
			cur_id_q      <= id_new;
			cur_tag_q     <= tag_new;
			cur_level_q   <= level_new;
			cur_quantum_q <= quantum_new;
			cur_done_q    <= done_new;
			if (reg_ok) begin
				next_id_q    <= next_id_q + ID_W'(1);
				task_count_q <= task_count_q + CNT_W'(1);
			end
		end
	end

	// Result register: the word reports the state left behind by the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.running_valid <= (id_new != '0);
			result_s2.running_id    <= id_new;
			result_s2.running_tag   <= tag_new;
			result_s2.switched      <= (item_s1.opcode == OP_TICK) && (id_new != cur_id_q);
			result_s2.register_ok   <= reg_ok;
			result_s2.assigned_id   <= reg_ok ? next_id_q : '0;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule
